FILE: hdl/ippra_pkg.sv
// Shared types and constants for the IPP response attribute parser.
// No dependencies; every other file refers to this package by scoped names.
package ippra_pkg;

    // Longest name kept per attribute is NAME_CAPACITY-1 bytes.
    localparam int NAME_CAPACITY = 256;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_VALUE  = 3'd2;
    localparam logic [2:0] KIND_ATTR   = 3'd3;
    localparam logic [2:0] KIND_OK     = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    localparam logic [7:0] TAG_END_OF_ATTRS = 8'h03;
    localparam logic [7:0] TAG_GROUP_MAX    = 8'h0F;
    localparam logic [15:0] HEADER_BYTES    = 16'd8;

    // One queued result; err_follows asks the back end for a trailing error beat.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] resp_status;
        logic [31:0] request_ident;
        logic [3:0]  grp_id;
        logic [7:0]  attr_tag;
        logic [15:0] value_length;
        logic        name_reused;
        logic [7:0]  out_byte;
        logic [15:0] byte_index;
        logic        end_of_item;
        logic        err_follows;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: hdl/ippra_front.sv
// Front end: message byte parser. Tracks header/TLV phase and builds queue entries.
// Depends on ippra_pkg.
module ippra_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_in_byte,
    input  logic                   s_final_byte,
    input  ippra_pkg::fifo_status_t q_status,
    output logic                   q_push,
    output ippra_pkg::entry_t      q_entry
);

    typedef enum logic [3:0] {
        PH_HDR, PH_TAG, PH_NLH, PH_NLL, PH_NAME, PH_VLH, PH_VLL, PH_VAL, PH_DONE
    } phase_t;

    localparam logic [16:0] NAME_KEEP = 17'(ippra_pkg::NAME_CAPACITY - 1);
    localparam logic [16:0] NAME_LAST = 17'(ippra_pkg::NAME_CAPACITY - 2);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [47:0] shift_reg, shift_next;
    logic [3:0]  group_reg, group_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] nrem_reg, nrem_next;
    logic [15:0] vrem_reg, vrem_next;
    logic        reuse_reg, reuse_next;

    logic [15:0]        pos_inc;
    logic               ended;
    logic               has_result;
    logic               accept;
    ippra_pkg::entry_t  ent;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign pos_inc = pos_reg + 16'd1;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        group_next = group_reg;
        tag_next   = tag_reg;
        nrem_next  = nrem_reg;
        vrem_next  = vrem_reg;
        reuse_next = reuse_reg;
        ended      = 1'b0;
        has_result = 1'b0;
        ent        = '0;

        case (phase_reg)
            PH_HDR: begin
                shift_next = {shift_reg[39:0], s_in_byte};
                pos_next   = pos_inc;
                if (pos_inc >= ippra_pkg::HEADER_BYTES) begin
                    has_result        = 1'b1;
                    ent.kind          = ippra_pkg::KIND_HEADER;
                    ent.resp_status   = shift_next[47:32];
                    ent.request_ident = shift_next[31:0];
                    pos_next          = '0;
                    phase_next        = PH_TAG;
                end
            end
            PH_TAG: begin
                if (s_in_byte == ippra_pkg::TAG_END_OF_ATTRS) begin
                    has_result = 1'b1;
                    ent.kind   = ippra_pkg::KIND_OK;
                    phase_next = PH_DONE;
                    ended      = 1'b1;
                end else if (s_in_byte <= ippra_pkg::TAG_GROUP_MAX) begin
                    group_next = s_in_byte[3:0];
                    reuse_next = 1'b0;
                end else begin
                    tag_next   = s_in_byte;
                    phase_next = PH_NLH;
                end
            end
            PH_NLH: begin
                nrem_next  = {s_in_byte, 8'h00};
                phase_next = PH_NLL;
            end
            PH_NLL: begin
                nrem_next = {nrem_reg[15:8], s_in_byte};
                pos_next  = '0;
                if (nrem_next != 16'd0) begin
                    reuse_next = 1'b1;
                    phase_next = PH_NAME;
                end else begin
                    phase_next = PH_VLH;
                end
            end
            PH_NAME: begin
                // bytes past capacity are consumed silently
                if ({1'b0, pos_reg} < NAME_KEEP) begin
                    has_result      = 1'b1;
                    ent.kind        = ippra_pkg::KIND_NAME;
                    ent.out_byte    = s_in_byte;
                    ent.byte_index  = pos_reg;
                    ent.end_of_item = (nrem_reg == 16'd1) || ({1'b0, pos_reg} == NAME_LAST);
                end
                pos_next  = pos_inc;
                nrem_next = nrem_reg - 16'd1;
                if (nrem_reg == 16'd1) begin
                    phase_next = PH_VLH;
                end
            end
            PH_VLH: begin
                vrem_next  = {s_in_byte, 8'h00};
                phase_next = PH_VLL;
            end
            PH_VLL: begin
                vrem_next        = {vrem_reg[15:8], s_in_byte};
                has_result       = 1'b1;
                ent.kind         = ippra_pkg::KIND_ATTR;
                ent.value_length = vrem_next;
                // pos is zero here only when the name was empty
                ent.name_reused  = (pos_reg == 16'd0) && reuse_reg;
                ent.end_of_item  = (vrem_next == 16'd0);
                pos_next         = '0;
                phase_next       = (vrem_next == 16'd0) ? PH_TAG : PH_VAL;
            end
            PH_VAL: begin
                has_result      = 1'b1;
                ent.kind        = ippra_pkg::KIND_VALUE;
                ent.out_byte    = s_in_byte;
                ent.byte_index  = pos_reg;
                ent.end_of_item = (vrem_reg == 16'd1);
                pos_next        = pos_inc;
                vrem_next       = vrem_reg - 16'd1;
                if (vrem_reg == 16'd1) begin
                    phase_next = PH_TAG;
                end
            end
            PH_DONE: begin
                ended = 1'b1;
            end
            default: begin
                ended = 1'b1;
            end
        endcase

        ent.grp_id   = group_next;
        ent.attr_tag = tag_next;

        if (s_final_byte) begin
            if (!ended) begin
                if (has_result) begin
                    ent.err_follows = 1'b1;
                end else begin
                    has_result = 1'b1;
                    ent.kind   = ippra_pkg::KIND_ERROR;
                end
            end
            phase_next = PH_HDR;
            pos_next   = '0;
            shift_next = '0;
            group_next = '0;
            tag_next   = '0;
            nrem_next  = '0;
            vrem_next  = '0;
            reuse_next = 1'b0;
        end
    end

    assign q_push  = accept && has_result;
    assign q_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            pos_reg   <= '0;
            shift_reg <= '0;
            group_reg <= '0;
            tag_reg   <= '0;
            nrem_reg  <= '0;
            vrem_reg  <= '0;
            reuse_reg <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            group_reg <= group_next;
            tag_reg   <= tag_next;
            nrem_reg  <= nrem_next;
            vrem_reg  <= vrem_next;
            reuse_reg <= reuse_next;
        end
    end

    // a trailing error beat only ever comes from the final byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_entry.err_follows |-> s_final_byte)
        else $error("error beat queued on a non-final byte");

    // the byte after a final byte restarts in the header phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_final_byte |=> phase_reg == PH_HDR && pos_reg == 16'd0)
        else $error("parser not reset after final byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HDR |-> pos_reg < ippra_pkg::HEADER_BYTES)
        else $error("header byte count overran");

endmodule

FILE: hdl/ippra_fifo.sv
// Short entry queue between the parser front end and the output back end.
// Depends on ippra_pkg.
module ippra_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  ippra_pkg::entry_t       push_entry,
    input  logic                    pop,
    output ippra_pkg::entry_t       head_entry,
    output ippra_pkg::fifo_status_t status
);

    ippra_pkg::entry_t mem [ippra_pkg::FIFO_DEPTH];

    logic [ippra_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ippra_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ippra_pkg::FIFO_AW:0]   count_reg, count_next;

    assign status.full  = (count_reg == (ippra_pkg::FIFO_AW + 1)'(ippra_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_entry   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !status.full)
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !status.empty)
        else $error("pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (ippra_pkg::FIFO_AW + 1)'(ippra_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: hdl/ippra_back.sv
// Back end: drains queue entries into the registered result channel and
// appends the error beat that a truncated message needs. Depends on ippra_pkg.
module ippra_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ippra_pkg::entry_t       head_entry,
    input  ippra_pkg::fifo_status_t q_status,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [2:0]              m_kind,
    output logic [15:0]             m_resp_status,
    output logic [31:0]             m_request_ident,
    output logic [3:0]              m_grp_id,
    output logic [7:0]              m_attr_tag,
    output logic [15:0]             m_value_length,
    output logic                    m_name_reused,
    output logic [7:0]              m_out_byte,
    output logic [15:0]             m_byte_index,
    output logic                    m_end_of_item,
    output logic                    m_last_of_run
);

    logic               valid_reg;
    logic               err_pend_reg;
    logic               last_reg;
    ippra_pkg::entry_t  beat_reg;
    logic               out_free;

    assign out_free = !valid_reg || m_ready;
    assign q_pop    = out_free && !err_pend_reg && !q_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            err_pend_reg <= 1'b0;
        end else if (out_free) begin
            if (err_pend_reg) begin
                valid_reg    <= 1'b1;
                err_pend_reg <= 1'b0;
            end else begin
                valid_reg    <= !q_status.empty;
                err_pend_reg <= !q_status.empty && head_entry.err_follows;
            end
        end
    end

    // payload: error beat keeps group/value tag of the beat before it
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (err_pend_reg) begin
                beat_reg.kind          <= ippra_pkg::KIND_ERROR;
                beat_reg.resp_status   <= '0;
                beat_reg.request_ident <= '0;
                beat_reg.value_length  <= '0;
                beat_reg.name_reused   <= 1'b0;
                beat_reg.out_byte      <= '0;
                beat_reg.byte_index    <= '0;
                beat_reg.end_of_item   <= 1'b0;
                beat_reg.err_follows   <= 1'b0;
                last_reg               <= 1'b1;
            end else if (!q_status.empty) begin
                beat_reg <= head_entry;
                last_reg <= !head_entry.err_follows;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_kind          = beat_reg.kind;
    assign m_resp_status   = beat_reg.resp_status;
    assign m_request_ident = beat_reg.request_ident;
    assign m_grp_id        = beat_reg.grp_id;
    assign m_attr_tag      = beat_reg.attr_tag;
    assign m_value_length  = beat_reg.value_length;
    assign m_name_reused   = beat_reg.name_reused;
    assign m_out_byte      = beat_reg.out_byte;
    assign m_byte_index    = beat_reg.byte_index;
    assign m_end_of_item   = beat_reg.end_of_item;
    assign m_last_of_run   = last_reg;

    // a pending error always sits behind a beat still on the port
    assert property (@(posedge aclk) disable iff (!aresetn) err_pend_reg |-> valid_reg)
        else $error("error pending with no beat in front");

    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (m_kind == ippra_pkg::KIND_ERROR || m_kind == ippra_pkg::KIND_OK)
        |-> m_last_of_run)
        else $error("terminal beat not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        err_pend_reg && m_ready |=> valid_reg && m_kind == ippra_pkg::KIND_ERROR)
        else $error("error beat not delivered after its predecessor");

endmodule

FILE: hdl/ipp_response_attribute_parser_unit.sv
// IPP response attribute parser: takes one message byte per beat and streams
// out header ids, attribute headers, name and value bytes, and ok/error.
// Input bytes are taken at one per cycle while the queue has room. Each byte
// yields zero or one result beat, and a final byte can yield two (a header,
// attribute, name or value beat, then error). The parser front end and the
// output register are decoupled by a 4-entry queue, so s_ready only drops when
// that queue fills under output backpressure. A result beat passes through
// the queue and then the output register. Names longer than NAME_CAPACITY-1
// bytes are cut; the remaining name bytes are consumed with no result. After
// an error the consumer discards the partial attribute.
module ipp_response_attribute_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_resp_status,
    output logic [31:0] m_request_ident,
    output logic [3:0]  m_grp_id,
    output logic [7:0]  m_attr_tag,
    output logic [15:0] m_value_length,
    output logic        m_name_reused,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_byte_index,
    output logic        m_end_of_item,
    output logic        m_last_of_run
);

    logic                    q_push;
    logic                    q_pop;
    ippra_pkg::entry_t       q_in;
    ippra_pkg::entry_t       q_head;
    ippra_pkg::fifo_status_t q_status;

    ippra_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_final_byte (s_final_byte),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    ippra_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head_entry (q_head),
        .status     (q_status)
    );

    ippra_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_entry      (q_head),
        .q_status        (q_status),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_resp_status   (m_resp_status),
        .m_request_ident (m_request_ident),
        .m_grp_id        (m_grp_id),
        .m_attr_tag      (m_attr_tag),
        .m_value_length  (m_value_length),
        .m_name_reused   (m_name_reused),
        .m_out_byte      (m_out_byte),
        .m_byte_index    (m_byte_index),
        .m_end_of_item   (m_end_of_item),
        .m_last_of_run   (m_last_of_run)
    );

endmodule
